[sv/dpt_pkg.sv]
// Shared widths and the witness table of the primality test unit.
package dpt_pkg;
	localparam int NUM_WIDTH = 63;
	// The multiplier operand that is scanned bit-serially must also hold the widest witness.
	localparam int MB_W  = (NUM_WIDTH > 31) ? NUM_WIDTH : 31;
	localparam int MC_W  = $clog2(MB_W + 1);
	localparam int SC_W  = $clog2(NUM_WIDTH + 1);
	localparam int NUM_BASES = 7;
	localparam int K_W   = 3;

	typedef logic [NUM_WIDTH-1:0] num_t;
	typedef logic [MB_W-1:0]      mb_t;

	function automatic mb_t base_val(input logic [K_W-1:0] k);
		mb_t v;
		case (k)
			3'd0: v = MB_W'(31'd2);
			3'd1: v = MB_W'(31'd325);
			3'd2: v = MB_W'(31'd9375);
			3'd3: v = MB_W'(31'd28178);
			3'd4: v = MB_W'(31'd450775);
			3'd5: v = MB_W'(31'd9780504);
			3'd6: v = MB_W'(31'd1795265022);
			default: v = MB_W'(31'd2);
		endcase
		return v;
	endfunction
endpackage

[sv/dpt_mulmod.sv]
// Bit-serial modular multiplier: one bit of b per cycle, most significant bit first.
module dpt_mulmod import dpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  num_t a,
	input  mb_t  b,
	input  num_t n,
	output logic done,
	output num_t res
);
	num_t                 acc_q;
	num_t                 a_q;
	mb_t                  b_q;
	logic [MC_W-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NUM_WIDTH+1:0] t;
	logic [NUM_WIDTH+1:0] nn;
	logic [NUM_WIDTH+1:0] n2;
	logic [NUM_WIDTH+1:0] r;

	// The accumulator stays below n and a is below n, so 2*acc + a is below 3n.
	always_comb begin
		nn = {2'b00, n};
		n2 = {1'b0, n, 1'b0};
		t  = {1'b0, acc_q, 1'b0} + (b_q[MB_W-1] ? {2'b00, a_q} : '0);
		if (t >= n2) begin
			r = t - n2;
		end else if (t >= nn) begin
			r = t - nn;
		end else begin
			r = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MC_W'(MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= r[NUM_WIDTH-1:0];
			b_q   <= {b_q[MB_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = acc_q;
endmodule

[sv/deterministic_primality_test_unit.sv]
// Top level of the deterministic primality test unit (seven-witness Miller-Rabin).
//
//  channel | handshake           | payload
//  input   | in_valid / in_stall   | number   (63 bits)
//  output  | out_valid / out_stall | is_prime (1 bit)
//
// A modular product is issued by the sequencer and then run in the bit-serial multiplier.
// Numbers below 4 and even numbers go straight to the result; others take up to 7 witnesses of
// at most 124 products each, fewer when a witness fails early.
// Reset clears the sequencer and the output slot; no clearing pass is needed.
// A finished result waits in the output register while the next number is taken in;
// the sequencer holds its own result only if that register is still occupied.
module deterministic_primality_test_unit import dpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [NUM_WIDTH-1:0] number,
	output logic out_valid,
	input  logic out_stall,
	output logic is_prime
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SPLIT = 4'd1;
	localparam logic [3:0] S_RED   = 4'd2;
	localparam logic [3:0] S_REDW  = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_SQW   = 4'd5;
	localparam logic [3:0] S_ML    = 4'd6;
	localparam logic [3:0] S_MLW   = 4'd7;
	localparam logic [3:0] S_CHK   = 4'd8;
	localparam logic [3:0] S_LOOP  = 4'd9;
	localparam logic [3:0] S_LW    = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0]      state_q;
	num_t            n_q;
	num_t            nm1_q;
	num_t            d_q;
	num_t            e_q;
	num_t            x_q;
	num_t            acc_q;
	logic [SC_W-1:0] s_q;
	logic [SC_W-1:0] i_q;
	logic [SC_W-1:0] cnt_q;
	logic [K_W-1:0]  k_q;
	logic            res_q;
	logic            out_vld_q;
	logic            prime_q;

	logic            m_start;
	num_t            m_a;
	mb_t             m_b;
	logic            m_done;
	num_t            m_res;
	logic            acc_one;
	logic            acc_nm1;
	logic            accept;

	assign acc_one = (acc_q == NUM_WIDTH'(1));
	assign acc_nm1 = (acc_q == nm1_q);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		m_start = 1'b0;
		m_a     = acc_q;
		m_b     = MB_W'(acc_q);
		case (state_q)
			S_RED: begin
				m_start = 1'b1;
				m_a     = NUM_WIDTH'(1);
				m_b     = base_val(k_q);
			end
			S_SQ: begin
				m_start = (cnt_q != SC_W'(NUM_WIDTH)) && !acc_one;
			end
			S_ML: begin
				m_start = e_q[NUM_WIDTH-1];
				m_a     = x_q;
			end
			S_LOOP: begin
				m_start = (i_q < s_q) && !acc_nm1;
			end
			default: begin
				m_start = 1'b0;
			end
		endcase
	end

	dpt_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m_start),
		.a      (m_a),
		.b      (m_b),
		.n      (n_q),
		.done   (m_done),
		.res    (m_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_vld_q || !out_stall)) begin
				// The slot is free, or its result is transferred in this cycle.
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (number[NUM_WIDTH-1:2] == '0 || !number[0]) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SPLIT;
						end
					end
				end
				S_SPLIT: begin
					if (d_q[0]) begin
						state_q <= S_RED;
					end
				end
				S_RED:  state_q <= S_REDW;
				S_REDW: begin
					if (m_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == SC_W'(NUM_WIDTH)) begin
						state_q <= S_CHK;
					end else if (acc_one) begin
						state_q <= S_ML;
					end else begin
						state_q <= S_SQW;
					end
				end
				S_SQW: begin
					if (m_done) begin
						state_q <= S_ML;
					end
				end
				S_ML: begin
					state_q <= e_q[NUM_WIDTH-1] ? S_MLW : S_SQ;
				end
				S_MLW: begin
					if (m_done) begin
						state_q <= S_SQ;
					end
				end
				S_CHK: begin
					if (acc_q <= NUM_WIDTH'(1)) begin
						state_q <= (k_q == '0) ? S_FIN : S_RED;
					end else begin
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if ((i_q < s_q) && !acc_nm1) begin
						state_q <= S_LW;
					end else if (!acc_nm1 || k_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RED;
					end
				end
				S_LW: begin
					if (m_done) begin
						state_q <= S_LOOP;
					end
				end
				S_FIN: begin
					if (!out_vld_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= number;
				nm1_q <= number - NUM_WIDTH'(1);
				d_q   <= number - NUM_WIDTH'(1);
				s_q   <= '0;
				k_q   <= K_W'(NUM_BASES - 1);
				res_q <= (number[NUM_WIDTH-1:2] == '0) ? number[1] : 1'b0;
			end
			S_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[NUM_WIDTH-1:1]};
					s_q <= s_q + 1'b1;
				end
			end
			S_REDW: begin
				if (m_done) begin
					x_q   <= m_res;
					acc_q <= NUM_WIDTH'(1);
					e_q   <= d_q;
					cnt_q <= '0;
				end
			end
			S_SQW: begin
				if (m_done) begin
					acc_q <= m_res;
				end
			end
			S_ML: begin
				if (!e_q[NUM_WIDTH-1]) begin
					e_q   <= {e_q[NUM_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_MLW: begin
				if (m_done) begin
					acc_q <= m_res;
					e_q   <= {e_q[NUM_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_CHK: begin
				i_q <= SC_W'(1);
				if (acc_q <= NUM_WIDTH'(1)) begin
					if (k_q == '0) begin
						res_q <= 1'b1;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
			end
			S_LOOP: begin
				if (!((i_q < s_q) && !acc_nm1)) begin
					if (!acc_nm1) begin
						res_q <= 1'b0;
					end else if (k_q == '0) begin
						res_q <= 1'b1;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
			end
			S_LW: begin
				if (m_done) begin
					acc_q <= m_res;
					i_q   <= i_q + 1'b1;
				end
			end
			S_FIN: begin
				if (!out_vld_q || !out_stall) begin
					prime_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_vld_q;
	assign is_prime  = prime_q;
endmodule
